// ===== sv/bams_pkg.sv =====
// ----------------------------------------------------------------------------
// bams_pkg: shared types and helpers
// Item types, widths and saturating arithmetic for the block averaging
// mean / sample deviation block.
// ----------------------------------------------------------------------------
package bams_pkg;

  localparam int SAMPLE_W = 32;   // signed Q16.16 sample
  localparam int COUNT_W  = 32;   // default counter width
  localparam int BSIZE_W  = 16;
  localparam logic [BSIZE_W-1:0] BSIZE_RST = 16'd16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mean_value;
    logic        [31:0] std_value;
    logic               used_blocks;
    logic        [31:0] value_count;
  } out_item_t;

  // sample after sign extension, as queued between front and back
  typedef struct packed {
    logic signed [63:0] x;
    logic               last;
  } work_t;

  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         go;
    logic         short_op;  // 64-bit dividend, 64 steps
    logic [127:0] num;
    logic [63:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        go;
    logic [63:0] op;
  } sqrt_req_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  function automatic logic [63:0] usat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // floor(p / 2^16) clipped to 64 bits
  function automatic logic [63:0] sq_q(input logic [127:0] p);
    return (|p[127:80]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[79:16];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    logic [63:0] u;
    u = v;
    return v[63] ? (~u + 64'd1) : u;
  endfunction

  // apply sign to a rounded quotient magnitude
  function automatic logic signed [63:0] signed_q(input logic neg, input logic [63:0] q);
    logic signed [63:0] r;
    if (!neg) begin
      r = q;
    end else if (q[63]) begin
      r = 64'sh8000_0000_0000_0000;
    end else begin
      r = ~q + 64'd1;
    end
    return r;
  endfunction

endpackage

// ===== sv/bams_front.sv =====
// ----------------------------------------------------------------------------
// bams_front: input side
// Accepts samples, sign extends them and queues them for the back end.
// ----------------------------------------------------------------------------
module bams_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bams_pkg::in_item_t in_item_i,
  output logic               q_valid_o,
  output bams_pkg::work_t    q_item_o,
  input  logic               q_pop_i
);

  bams_pkg::work_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;
  bams_pkg::work_t wr_item;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_item.x    = 64'(in_item_i.sample);  // signed source: sign extends
    wr_item.last = in_item_i.last;
    wr_ptr_d     = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d     = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d        = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

endmodule

// ===== sv/bams_mul.sv =====
// ----------------------------------------------------------------------------
// bams_mul: 64x64 multiplier
// Four 32x32 partial products, one per cycle, summed into a 128-bit result.
// ----------------------------------------------------------------------------
module bams_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bams_pkg::mul_req_t req_i,
  output logic               done_o,
  output logic [127:0]       prod_o
);

  logic [63:0]  a_q, b_q;
  logic [2:0]   cnt_q;
  logic         busy_q, pp_v_q, done_q;
  logic [63:0]  pp_q;
  logic [1:0]   pp_idx_q;
  logic [127:0] acc_q;
  logic [31:0]  a_h, b_h;
  logic [127:0] pp_sh;

  assign a_h    = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_h    = cnt_q[0] ? b_q[63:32] : b_q[31:0];
  assign done_o = done_q;
  assign prod_o = acc_q;

  always_comb begin
    case (pp_idx_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd3:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = {32'd0, pp_q, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      pp_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
        pp_v_q <= 1'b0;
      end else if (busy_q) begin
        pp_v_q <= (cnt_q != 3'd4);
        cnt_q  <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q     <= a_h * b_h;
        pp_idx_q <= cnt_q[1:0];
      end
      if (pp_v_q) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

endmodule

// ===== sv/bams_div.sv =====
// ----------------------------------------------------------------------------
// bams_div: restoring divider
// floor(num / den), one quotient bit per cycle; 64 or 128 steps.
// ----------------------------------------------------------------------------
module bams_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bams_pkg::div_req_t req_i,
  output logic               done_o,
  output logic [127:0]       quot_o
);

  logic [127:0] a_q, q_q;
  logic [63:0]  rem_q, d_q;
  logic [7:0]   cnt_q;
  logic         busy_q, done_q;
  logic [63:0]  rem_sh;
  logic         ge;

  assign rem_sh = {rem_q[62:0], a_q[127]};
  // bit shifted out of the remainder counts as a guaranteed subtract
  assign ge     = rem_q[63] || (rem_sh >= d_q);
  assign done_o = done_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 8'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_op ? 8'd64 : 8'd128;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      a_q   <= req_i.short_op ? {req_i.num[63:0], 64'd0} : req_i.num;
      d_q   <= req_i.den;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[126:0], 1'b0};
      rem_q <= ge ? (rem_sh - d_q) : rem_sh;
      q_q   <= {q_q[126:0], ge};
    end
  end

endmodule

// ===== sv/bams_sqrt.sv =====
// ----------------------------------------------------------------------------
// bams_sqrt: integer square root
// floor(sqrt(op)) for a 64-bit operand, one result bit per cycle.
// ----------------------------------------------------------------------------
module bams_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bams_pkg::sqrt_req_t req_i,
  output logic                done_o,
  output logic [31:0]         root_o
);

  logic [63:0] v_q, res_q, bit_q, t;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;

  assign t      = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      v_q   <= req_i.op;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= t) begin
        v_q   <= v_q - t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ===== sv/bams_back.sv =====
// ----------------------------------------------------------------------------
// bams_back: accumulation and result sequencer
// Keeps the sample and block-mean sums and works out mean and deviation.
// ----------------------------------------------------------------------------
module bams_back #(
  parameter int COUNT_WIDTH = bams_pkg::COUNT_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bams_pkg::BSIZE_W-1:0] bsize_i,
  input  logic                         q_valid_i,
  input  bams_pkg::work_t              q_item_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bams_pkg::out_item_t          out_item_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQX   = 4'd1;
  localparam logic [3:0] ST_BMDIV = 4'd2;
  localparam logic [3:0] ST_BMSQ  = 4'd3;
  localparam logic [3:0] ST_LAST  = 4'd4;
  localparam logic [3:0] ST_MEAN  = 4'd5;
  localparam logic [3:0] ST_SS    = 4'd6;
  localparam logic [3:0] ST_BDIV  = 4'd7;
  localparam logic [3:0] ST_DDIV  = 4'd8;
  localparam logic [3:0] ST_SQRT  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [3:0]                  state_q, state_d;
  logic signed [63:0]          x_q, x_d;
  logic                        last_q, last_d;
  logic [COUNT_WIDTH-1:0]      cnt_q, cnt_d, bcnt_q, bcnt_d;
  logic signed [63:0]          ssum_q, ssum_d, bsum_q, bsum_d, bmsum_q, bmsum_d;
  logic [63:0]                 ssq_q, ssq_d, bmsq_q, bmsq_d;
  logic [bams_pkg::BSIZE_W-1:0] fill_q, fill_d;
  logic signed [63:0]          bm_q, bm_d, s_q, s_d;
  logic [63:0]                 qs_q, qs_d, n_q, n_d;
  logic                        blocks_q, blocks_d;
  logic [31:0]                 mean_q, mean_d, std_q, std_d;
  logic                        out_valid_q, out_valid_d;
  bams_pkg::out_item_t         out_item_q, out_item_d;

  bams_pkg::mul_req_t  mul_req;
  bams_pkg::div_req_t  div_req;
  bams_pkg::sqrt_req_t sqrt_req;
  logic                mul_done, div_done, sqrt_done;
  logic [127:0]        mul_prod, div_quot;
  logic [31:0]         sqrt_root;

  bams_mul u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(mul_req), .done_o(mul_done), .prod_o(mul_prod)
  );
  bams_div u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(div_req), .done_o(div_done), .quot_o(div_quot)
  );
  bams_sqrt u_sqrt (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(sqrt_req), .done_o(sqrt_done),
    .root_o(sqrt_root)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    logic [16:0]        fill_inc;
    logic signed [63:0] bsum_new, bm, mean64, s_sel;
    logic [63:0]        n_sel;
    logic [127:0]       a_w;
    logic               use_blk;

    state_d     = state_q;
    x_d         = x_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    bcnt_d      = bcnt_q;
    ssum_d      = ssum_q;
    bsum_d      = bsum_q;
    bmsum_d     = bmsum_q;
    ssq_d       = ssq_q;
    bmsq_d      = bmsq_q;
    fill_d      = fill_q;
    bm_d        = bm_q;
    s_d         = s_q;
    qs_d        = qs_q;
    n_d         = n_q;
    blocks_d    = blocks_q;
    mean_d      = mean_q;
    std_d       = std_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    mul_req     = '0;
    div_req     = '0;
    sqrt_req    = '0;

    fill_inc = {1'b0, fill_q} + 17'd1;
    bsum_new = bams_pkg::sat_add(bsum_q, x_q);
    bm       = bams_pkg::signed_q(bsum_q[63], div_quot[63:0]);
    mean64   = bams_pkg::signed_q(s_q[63], div_quot[63:0]);
    use_blk  = (bsize_i != '0) && (64'(cnt_q) >= 64'(bsize_i)) && (bcnt_q != '0);
    s_sel    = use_blk ? bmsum_q : ssum_q;
    n_sel    = use_blk ? 64'(bcnt_q) : 64'(cnt_q);
    a_w      = {48'd0, qs_q, 16'd0};

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          x_d       = q_item_i.x;
          last_d    = q_item_i.last;
          mul_req.go = 1'b1;
          mul_req.a  = bams_pkg::mag(q_item_i.x);
          mul_req.b  = bams_pkg::mag(q_item_i.x);
          state_d   = ST_SQX;
        end
      end
      ST_SQX: begin
        if (mul_done) begin
          cnt_d   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
          ssum_d  = bams_pkg::sat_add(ssum_q, x_q);
          ssq_d   = bams_pkg::usat_add(ssq_q, bams_pkg::sq_q(mul_prod));
          state_d = ST_LAST;
          if (bsize_i != '0) begin
            bsum_d = bsum_new;
            fill_d = fill_inc[15:0];
            if (fill_inc >= {1'b0, bsize_i}) begin
              // block closes: rounded mean = (|sum| + fill/2) / fill
              div_req.go       = 1'b1;
              div_req.short_op = 1'b1;
              div_req.num      = {64'd0, bams_pkg::mag(bsum_new) + 64'(fill_inc[16:1])};
              div_req.den      = 64'(fill_inc);
              state_d          = ST_BMDIV;
            end
          end
        end
      end
      ST_BMDIV: begin
        if (div_done) begin
          bm_d       = bm;
          mul_req.go = 1'b1;
          mul_req.a  = bams_pkg::mag(bm);
          mul_req.b  = bams_pkg::mag(bm);
          state_d    = ST_BMSQ;
        end
      end
      ST_BMSQ: begin
        if (mul_done) begin
          bcnt_d  = (bcnt_q == CNT_MAX) ? bcnt_q : bcnt_q + 1'b1;
          bmsum_d = bams_pkg::sat_add(bmsum_q, bm_q);
          bmsq_d  = bams_pkg::usat_add(bmsq_q, bams_pkg::sq_q(mul_prod));
          fill_d  = '0;
          bsum_d  = '0;
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else begin
          blocks_d         = use_blk;
          s_d              = s_sel;
          qs_d             = use_blk ? bmsq_q : ssq_q;
          n_d              = n_sel;
          div_req.go       = 1'b1;
          div_req.short_op = 1'b1;
          div_req.num      = {64'd0, bams_pkg::mag(s_sel) + (n_sel >> 1)};
          div_req.den      = n_sel;
          state_d          = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          if (mean64 > 64'sh0000_0000_7FFF_FFFF) begin
            mean_d = 32'h7FFF_FFFF;
          end else if (mean64 < -64'sh0000_0000_8000_0000) begin
            mean_d = 32'h8000_0000;
          end else begin
            mean_d = mean64[31:0];
          end
          if (n_q < 64'd2) begin
            std_d   = '0;
            state_d = ST_FIN;
          end else begin
            mul_req.go = 1'b1;
            mul_req.a  = bams_pkg::mag(s_q);
            mul_req.b  = bams_pkg::mag(s_q);
            state_d    = ST_SS;
          end
        end
      end
      ST_SS: begin
        if (mul_done) begin
          div_req.go  = 1'b1;
          div_req.num = mul_prod;
          div_req.den = n_q;
          state_d     = ST_BDIV;
        end
      end
      ST_BDIV: begin
        // div_quot holds floor(S*S / n)
        if (div_done) begin
          if (a_w <= div_quot) begin
            std_d   = '0;
            state_d = ST_FIN;
          end else begin
            div_req.go  = 1'b1;
            div_req.num = a_w - div_quot;
            div_req.den = n_q - 64'd1;
            state_d     = ST_DDIV;
          end
        end
      end
      ST_DDIV: begin
        if (div_done) begin
          if (div_quot[127:64] != '0) begin
            std_d   = 32'hFFFF_FFFF;
            state_d = ST_FIN;
          end else begin
            sqrt_req.go = 1'b1;
            sqrt_req.op = div_quot[63:0];
            state_d     = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          std_d   = sqrt_root;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_item_d.mean_value  = mean_q;
          out_item_d.std_value   = std_q;
          out_item_d.used_blocks = blocks_q;
          out_item_d.value_count = (n_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n_q[31:0];
          cnt_d   = '0;
          ssum_d  = '0;
          ssq_d   = '0;
          fill_d  = '0;
          bsum_d  = '0;
          bcnt_d  = '0;
          bmsum_d = '0;
          bmsq_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ssum_q      <= '0;
      ssq_q       <= '0;
      fill_q      <= '0;
      bsum_q      <= '0;
      bcnt_q      <= '0;
      bmsum_q     <= '0;
      bmsq_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ssum_q      <= ssum_d;
      ssq_q       <= ssq_d;
      fill_q      <= fill_d;
      bsum_q      <= bsum_d;
      bcnt_q      <= bcnt_d;
      bmsum_q     <= bmsum_d;
      bmsq_q      <= bmsq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    last_q     <= last_d;
    bm_q       <= bm_d;
    s_q        <= s_d;
    qs_q       <= qs_d;
    n_q        <= n_d;
    blocks_q   <= blocks_d;
    mean_q     <= mean_d;
    std_q      <= std_d;
    out_item_q <= out_item_d;
  end

endmodule

// ===== sv/block_average_mean_stddev.sv =====
// ----------------------------------------------------------------------------
// block_average_mean_stddev: block-averaged mean and sample deviation
// Streams signed Q16.16 samples, averages them in blocks of block_size and
// reports the mean of the block means and their N-1 standard deviation on
// the sample marked last (plain statistics over all samples as fallback).
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------
//  in      | in  | in_valid_i / in_stall_o   | in_item_i  (sample, last)
//  out     | out | out_valid_o / out_stall_i | out_item_o (mean, std, ...)
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i (block_size)
//
// A sample runs in order through the queue pop, the 5-step 64x64
// multiplier that squares it, the fold into the sums and the last check.
// A sample that closes a block adds the 64-step rounding divide and the
// block-mean square. The last sample adds the 64-step mean divide, the
// square of the sum, two 128-step divides and a 32-step square root; all
// divides share one divider.
// Reset clears all sums and loads block_size with 16; no clearing pass.
// The two-entry input queue keeps accepting while the back end is busy; a
// stalled result holds in the output register and blocks only the next last.
// ----------------------------------------------------------------------------
module block_average_mean_stddev #(
  parameter int COUNT_WIDTH = bams_pkg::COUNT_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bams_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bams_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bams_pkg::BSIZE_W-1:0] cfg_data_i
);

  logic [bams_pkg::BSIZE_W-1:0] bsize_q;
  logic                         q_valid, q_pop;
  bams_pkg::work_t              q_item;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= bams_pkg::BSIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bsize_q <= cfg_data_i;
    end
  end

  // front: accept and sign extend, queue up to two samples
  bams_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: sums, block means, final mean / deviation
  bams_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bsize_i    (bsize_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for block_average_mean_stddev
// Streams data sets of Q16.16 samples under random idling and stalls. A
// software twin of the block keeps the block sums and predicts each
// mean / deviation result. Every result is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam int DRAIN_CYCLES = 1000;   // room for a last sample to finish
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bams_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bams_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bams_pkg::BSIZE_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  block_average_mean_stddev u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // control shared between the test flow and the side processes
  bit quiet = 1'b0;           // no random idling on either side
  int hold_req = 0;           // bumped to start a long output hold
  int errors = 0;
  int items_sent = 0;
  bams_pkg::out_item_t pending_stats[$];

  // ---------------------------------------------------------------- twin --
  logic [15:0] bsize;
  logic [31:0] n_seen;
  logic signed [63:0] tot_sum;
  logic [63:0] tot_sq;
  logic [16:0] fill;
  logic signed [63:0] blk_acc;
  logic [31:0] n_blocks;
  logic signed [63:0] mean_sum;
  logic [63:0] mean_sq;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] add_usat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? U64_MAX : s[63:0];
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Q16.16 square, floor, clipped
  function automatic logic [63:0] square_q16(logic signed [63:0] v);
    logic [127:0] p;
    p = abs64(v) * abs64(v);
    return (|p[127:80]) ? U64_MAX : p[79:16];
  endfunction

  // nearest, ties away from zero
  function automatic logic signed [63:0] round_div(logic signed [63:0] s, logic [63:0] n);
    logic [64:0] q;
    q = ({1'b0, abs64(s)} + (n >> 1)) / n;
    if (!s[63]) return q[63:0];
    if (q >= 65'h1_0000_0000_0000_0000 >> 1) return S64_MIN;
    return -$signed(q[63:0]);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (128'(t) * 128'(t) <= 128'(v)) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] sample_std(logic signed [63:0] s, logic [63:0] q,
                                            logic [63:0] n);
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] d;
    if (n < 2) return '0;
    a = 128'(q) << 16;
    b = (128'(abs64(s)) * 128'(abs64(s))) / 128'(n);
    if (a <= b) return '0;
    d = (a - b) / 128'(n - 1);
    if (|d[127:64]) return CNT_MAX;
    return root_floor(d[63:0]);
  endfunction

  function automatic void clear_sums();
    n_seen = '0; tot_sum = '0; tot_sq = '0; fill = '0; blk_acc = '0;
    n_blocks = '0; mean_sum = '0; mean_sq = '0;
  endfunction

  // folds one accepted sample into the twin; queues a result on last
  function automatic void fold_sample(bams_pkg::in_item_t it);
    logic signed [63:0] x;
    logic signed [63:0] bm;
    logic signed [63:0] s;
    logic signed [63:0] m;
    logic [63:0] q;
    logic [63:0] n;
    logic blocks;
    bams_pkg::out_item_t r;
    x = 64'(it.sample);
    if (n_seen != CNT_MAX) n_seen++;
    tot_sum = add_sat(tot_sum, x);
    tot_sq = add_usat(tot_sq, square_q16(x));
    if (bsize != 0) begin
      blk_acc = add_sat(blk_acc, x);
      fill++;
      if (fill >= bsize) begin
        bm = round_div(blk_acc, 64'(fill));
        if (n_blocks != CNT_MAX) n_blocks++;
        mean_sum = add_sat(mean_sum, bm);
        mean_sq = add_usat(mean_sq, square_q16(bm));
        fill = '0;
        blk_acc = '0;
      end
    end
    if (!it.last) return;
    blocks = bsize != 0 && n_seen >= bsize && n_blocks != 0;
    if (blocks) begin
      s = mean_sum; q = mean_sq; n = 64'(n_blocks);
    end else begin
      s = tot_sum; q = tot_sq; n = 64'(n_seen);
    end
    m = round_div(s, n);
    if (m > 64'sh7FFF_FFFF) m = 64'sh7FFF_FFFF;
    if (m < -64'sh8000_0000) m = -64'sh8000_0000;
    r.mean_value = m[31:0];
    r.std_value = sample_std(s, q, n);
    r.used_blocks = blocks;
    r.value_count = n[31:0];
    pending_stats.insert(pending_stats.size(), r);
    clear_sums();
  endfunction

  // ------------------------------------------------------------ checking --
  always @(posedge clk) begin
    bams_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $error("unexpected result mean=%h std=%h", out_item.mean_value,
               out_item.std_value);
        errors++;
      end else begin
        e = pending_stats.pop_front();
        if (out_item.mean_value !== e.mean_value) begin
          $error("mean_value exp %h got %h", e.mean_value, out_item.mean_value);
          errors++;
        end
        if (out_item.std_value !== e.std_value) begin
          $error("std_value exp %h got %h", e.std_value, out_item.std_value);
          errors++;
        end
        if (out_item.used_blocks !== e.used_blocks) begin
          $error("used_blocks exp %b got %b", e.used_blocks, out_item.used_blocks);
          errors++;
        end
        if (out_item.value_count !== e.value_count) begin
          $error("value_count exp %0d got %0d", e.value_count, out_item.value_count);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold on request
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 13);
    end
  end

  // watchdog on cycles without any accepted item
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------- driving --
  task automatic send_item(logic signed [31:0] smp, logic lst);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{sample: smp, last: lst};
    do @(posedge clk); while (in_stall);
    fold_sample('{sample: smp, last: lst});
    items_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  // block must be idle: drain, then allow for a block close still in flight
  task automatic write_block_size(logic [15:0] v);
    stop_sending();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bsize = v;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_sample(int spread);
    if ($urandom_range(9) == 0) return $urandom();
    return 32'sh0003_0000 + $signed(32'($urandom_range(2 * spread))) - spread;
  endfunction

  task automatic send_set(int len, int spread);
    for (int i = 0; i < len; i++) send_item(rand_sample(spread), i == len - 1);
  endtask

  // ---------------------------------------------------------------- tests --
  task automatic test_directed();
    // reset size 16: one full block plus a dropped tail
    for (int i = 0; i < 20; i++) send_item(32'sh0001_0000 * i, i == 19);
    send_item(32'sh7FFF_FFFF, 1'b1);           // single value, no deviation
    send_item(32'sh7FFF_FFFF, 1'b0);           // extremes of the sample
    send_item(-32'sh8000_0000, 1'b0);
    send_item(-32'sh8000_0000, 1'b1);
    write_block_size(16'd0);                   // plain statistics
    send_set(3, 32'h100);
    write_block_size(16'hFFFF);                // fewer samples than a block
    send_set(4, 32'h1_0000);
    write_block_size(16'd1);
    send_set(5, 32'h8000);
  endtask

  // size shrinks while a block is partly full: it closes on the next sample
  task automatic test_size_change();
    write_block_size(16'd6);
    for (int i = 0; i < 4; i++) send_item(rand_sample(32'h2000), 1'b0);  // keeps state
    stop_sending();
    send_item(32'sh0002_0000, 1'b0);
    write_block_size(16'd2);
    send_set(5, 32'h2000);
    write_block_size(16'd3);                   // first block never closes
    send_set(2, 32'h2000);
  endtask

  // receiver holds off long enough to fill the block and stall its input
  task automatic test_backpressure();
    hold_req++;
    for (int k = 0; k < 4; k++) send_set(3, 32'h4000);
    stop_sending();
    wait_results();
  endtask

  task automatic test_random(int target);
    int sets = 0;
    logic [15:0] sizes[8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd7, 16'd8, 16'hFFFF};
    while (items_sent < target) begin
      if (sets % 6 == 5) write_block_size(sizes[$urandom_range(7)]);
      quiet = (sets >= 10 && sets < 16);
      send_set($urandom_range(1, 30), $urandom_range(1, 32'h0010_0000));
      if (sets == 20) test_backpressure();
      sets++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    bsize = bams_pkg::BSIZE_RST;
    clear_sums();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_size_change();
    test_backpressure();
    test_random(800);
    stop_sending();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
